// ===== rtl/hexp_pkg.sv =====
// ----------------------------------------------------------------------------
// hexp_pkg
// Shared types and codes for the hex text to bytes parser.
// ----------------------------------------------------------------------------
package hexp_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QPTR_W              = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;
   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   // word function codes
   localparam logic [1:0] FUNC_CHAR      = 2'd0;
   localparam logic [1:0] FUNC_END_ARG   = 2'd1;
   localparam logic [1:0] FUNC_END_INPUT = 2'd2;

   // sticky error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BADCHAR  = 2'd1;
   localparam logic [1:0] ERR_ODD      = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   localparam logic [2:0] STATUS_RUNNING = 3'd0;
   localparam logic [2:0] STATUS_DONE    = 3'd4;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] ch;
   } hexp_req_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  out_byte;
      logic [2:0]  status;
      logic [15:0] byte_count;
   } hexp_rsp_type;

   // classified word between front and back
   typedef struct packed {
      logic [1:0] func;
      logic       is_hex;
      logic       is_sep;
      logic       is_zero;
      logic       is_x;
      logic [3:0] nibble;
   } hexp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hexp_qstat_type;

endpackage

// ===== rtl/hexp_front.sv =====
// ----------------------------------------------------------------------------
// hexp_front
// Accepts input words and classifies each character for the back end.
// ----------------------------------------------------------------------------
module hexp_front
   import hexp_pkg::*;
(
   input  logic           push,
   output logic           full,
   input  hexp_req_type   req_data,
   input  hexp_qstat_type q_stat,
   output logic           q_push,
   output hexp_entry_type q_entry
);

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_SPACE = 8'h20;

   logic is_dec;
   logic is_alpha;
   logic [7:0] ch;

   assign ch       = req_data.ch;
   assign is_dec   = (ch >= CH_0) && (ch <= CH_9);
   assign is_alpha = ((ch >= CH_LA) && (ch <= CH_LF)) || ((ch >= CH_UA) && (ch <= CH_UF));

   assign full   = q_stat.full;
   assign q_push = push && !q_stat.full;

   always_comb begin
      q_entry.func    = req_data.func;
      q_entry.is_hex  = is_dec || is_alpha;
      q_entry.is_sep  = (ch == CH_COLON) || (ch == CH_COMMA) || (ch == CH_DASH) ||
                        (ch == CH_UNDER) || (ch == CH_SPACE);
      q_entry.is_zero = (ch == CH_0);
      q_entry.is_x    = (ch == CH_LX) || (ch == CH_UX);
      // letters a-f and A-F share low bits 1..6
      q_entry.nibble  = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
   end

endmodule

// ===== rtl/hexp_queue.sv =====
// ----------------------------------------------------------------------------
// hexp_queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module hexp_queue
   import hexp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_push,
   input  hexp_entry_type q_entry,
   input  logic           q_pop,
   output hexp_entry_type q_head,
   output hexp_qstat_type q_stat
);

   hexp_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(q_push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_entry;
      end
   end

   assign q_head       = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

// ===== rtl/hexp_back.sv =====
// ----------------------------------------------------------------------------
// hexp_back
// Parser state, byte assembly and the result register.
// ----------------------------------------------------------------------------
module hexp_back
   import hexp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  hexp_entry_type q_head,
   input  hexp_qstat_type q_stat,
   output logic           q_pop,
   input  logic [15:0]    capacity,
   output logic           empty,
   input  logic           pop,
   output hexp_rsp_type   rsp_data
);

   localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   logic [3:0]             held_ff, held_in;
   logic                   pend_ff, pend_in;
   logic [1:0]             pos_ff, pos_in;
   logic                   fwz_ff, fwz_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [1:0]             err_ff, err_in;
   logic                   out_valid_ff, out_valid_in;
   hexp_rsp_type           rsp_ff, rsp_in;

   logic                   fire;
   logic                   at_limit;
   logic                   handled;
   logic [EXT_W-1:0]       cnt_ext;

   localparam logic [1:0] POS_START  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_BEYOND = 2'd2;

   assign fire  = !q_stat.empty && (!out_valid_ff || pop);
   assign q_pop = fire;

   assign at_limit = (EXT_W'(cnt_ff) >= EXT_W'(capacity)) || (cnt_ff == '1);

   always_comb begin
      held_in = held_ff;
      pend_in = pend_ff;
      pos_in  = pos_ff;
      fwz_in  = fwz_ff;
      cnt_in  = cnt_ff;
      err_in  = err_ff;
      handled = 1'b0;
      rsp_in.byte_valid = 1'b0;
      rsp_in.out_byte   = '0;

      unique case (q_head.func)
         FUNC_CHAR: begin
            if (err_ff == ERR_NONE) begin
               unique case (pos_ff)
                  POS_START: begin
                     pos_in = POS_SECOND;
                     fwz_in = q_head.is_zero;
                  end
                  POS_SECOND: begin
                     pos_in = POS_BEYOND;
                     // 0x prefix: withdraw the tentative zero nibble
                     if (fwz_ff && q_head.is_x) begin
                        pend_in = 1'b0;
                        held_in = '0;
                        handled = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (!handled && !q_head.is_sep) begin
                  priority if (!q_head.is_hex) begin
                     err_in = ERR_BADCHAR;
                  end else if (!pend_ff) begin
                     held_in = q_head.nibble;
                     pend_in = 1'b1;
                  end else if (at_limit) begin
                     err_in = ERR_OVERFLOW;
                  end else begin
                     rsp_in.byte_valid = 1'b1;
                     rsp_in.out_byte   = {held_ff, q_head.nibble};
                     cnt_in  = cnt_ff + 1'b1;
                     pend_in = 1'b0;
                     held_in = '0;
                  end
               end
            end
         end
         FUNC_END_ARG, FUNC_END_INPUT: begin
            if (err_ff == ERR_NONE && pend_ff) begin
               err_in = ERR_ODD;
            end
            pend_in = 1'b0;
            held_in = '0;
            pos_in  = POS_START;
            fwz_in  = 1'b0;
         end
         default: begin
         end
      endcase

      cnt_ext = EXT_W'(cnt_in);
      if (q_head.func == FUNC_END_INPUT) begin
         if (err_in == ERR_NONE) begin
            rsp_in.status     = STATUS_DONE;
            rsp_in.byte_count = cnt_ext[15:0];
         end else begin
            rsp_in.status     = {1'b0, err_in};
            rsp_in.byte_count = '0;
         end
         cnt_in = '0;
         err_in = ERR_NONE;
      end else begin
         rsp_in.status     = {1'b0, err_in};
         rsp_in.byte_count = cnt_ext[15:0];
      end

      priority if (fire) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         pend_ff      <= 1'b0;
         pos_ff       <= POS_START;
         fwz_ff       <= 1'b0;
         cnt_ff       <= '0;
         err_ff       <= ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            held_ff <= held_in;
            pend_ff <= pend_in;
            pos_ff  <= pos_in;
            fwz_ff  <= fwz_in;
            cnt_ff  <= cnt_in;
            err_ff  <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/hex_text_to_bytes_parser.sv =====
// ----------------------------------------------------------------------------
// hex_text_to_bytes_parser
// Streaming ASCII hex text to byte parser with a capacity register.
// ----------------------------------------------------------------------------
// a pushed word is written into the queue, then its result into the result register
// throughput: one word per cycle while results are popped, set by the back end state update
// a four-entry queue between classifier and back end absorbs result stalls
// reset (synchronous) empties the queue and result register, clears parser state
// and sets byte_capacity to 256
module hex_text_to_bytes_parser
   import hexp_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  hexp_req_type          req_data,
   output logic                  empty,
   input  logic                  pop,
   output hexp_rsp_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic           q_push;
   logic           q_pop;
   hexp_entry_type q_entry;
   hexp_entry_type q_head;
   hexp_qstat_type q_stat;
   logic [15:0]    capacity_ff, capacity_in;
   logic           csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && paddr[2] == CSR_IDX_CAPACITY) begin
         capacity_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_CAPACITY) ? {16'd0, capacity_ff} : '0;

   hexp_front u_front (
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_stat   (q_stat),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   hexp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_stat  (q_stat)
   );

   hexp_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .capacity (capacity_ff),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // a completed byte never rides with an error or done status
   a_byte_running: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.byte_valid) |-> (rsp_data.status == STATUS_RUNNING))
      else $error("byte emitted with non-running status");

   // a byte just emitted means the count is nonzero
   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.byte_valid) |-> (rsp_data.byte_count != 16'd0))
      else $error("byte emitted with zero count");

   // back end only drains a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   // reset leaves both sides empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not empty after reset");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the hex text to bytes parser against a cycle-free predictor. Words go
// in through the push/full queue port in random bursts and come out through
// the empty/pop port with its own stall pattern. Every result word is checked
// field by field. The byte capacity register is set over the APB-style port
// between phases and read back.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hexp_pkg::*;

   localparam int          COUNT_WIDTH = COUNT_WIDTH_DEFAULT;
   localparam longint      COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 1;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam logic [4:0]  NOT_HEX     = 5'h10;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'({CSR_IDX_CAPACITY, 2'b00});
   localparam int          IDLE_LIMIT  = 2000;
   localparam int          PHASE_WORDS = 255;

   class hex_bytes_tracker;
      logic [15:0]  capacity;
      logic [3:0]   held;
      bit           half_byte;
      logic [1:0]   arg_pos;
      bit           lead_zero;
      longint       made;
      logic [1:0]   err;
      hexp_rsp_type pending_results[$];
      int           errors;

      function new();
         capacity = CAPACITY_RESET;
         errors   = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         held      = '0;
         half_byte = 0;
         arg_pos   = '0;
         lead_zero = 0;
         made      = 0;
         err       = ERR_NONE;
      endfunction

      function void close_arg();
         if (err == ERR_NONE && half_byte) begin
            err = ERR_ODD;
         end
         half_byte = 0;
         held      = '0;
         arg_pos   = '0;
         lead_zero = 0;
      endfunction

      function logic [4:0] hex_value(logic [7:0] c);
         if (c >= "0" && c <= "9") return 5'(c - "0");
         if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
         if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
         return NOT_HEX;
      endfunction

      function bit is_separator(logic [7:0] c);
         return c == ":" || c == "," || c == "-" || c == "_" || c == " ";
      endfunction

      function void take_word(hexp_req_type w);
         hexp_rsp_type r;
         bit           prefix_x;
         logic [4:0]   v;
         r        = '0;
         prefix_x = 0;
         if (w.func == FUNC_CHAR && err == ERR_NONE) begin
            if (arg_pos == 2'd0) begin
               arg_pos   = 2'd1;
               lead_zero = (w.ch == "0");
            end else if (arg_pos == 2'd1) begin
               arg_pos = 2'd2;
               // 0x prefix: drop the tentative zero nibble
               if (lead_zero && (w.ch == "x" || w.ch == "X")) begin
                  half_byte = 0;
                  held      = '0;
                  prefix_x  = 1;
               end
            end
            if (!prefix_x && !is_separator(w.ch)) begin
               v = hex_value(w.ch);
               if (v == NOT_HEX) begin
                  err = ERR_BADCHAR;
               end else if (!half_byte) begin
                  held      = v[3:0];
                  half_byte = 1;
               end else if (made >= capacity || made >= COUNT_MAX) begin
                  err = ERR_OVERFLOW;
               end else begin
                  r.byte_valid = 1'b1;
                  r.out_byte   = {held, v[3:0]};
                  made         = made + 1;
                  half_byte    = 0;
                  held         = '0;
               end
            end
         end else if (w.func == FUNC_END_ARG) begin
            close_arg();
         end
         if (w.func == FUNC_END_INPUT) begin
            close_arg();
            if (err == ERR_NONE) begin
               r.status     = STATUS_DONE;
               r.byte_count = 16'(made);
            end else begin
               r.status     = {1'b0, err};
               r.byte_count = '0;
            end
            clear_stream();
         end else begin
            r.status     = {1'b0, err};
            r.byte_count = 16'(made);
         end
         pending_results.push_back(r);
      endfunction

      function void match_result(hexp_rsp_type got);
         hexp_rsp_type want;
         if (pending_results.size() == 0) begin
            $error("result word with none expected: %h", got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
            errors++;
         end
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
            errors++;
         end
      endfunction
   endclass

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  push     = 1'b0;
   logic                  full;
   hexp_req_type          req_data = '0;
   logic                  empty;
   logic                  pop      = 1'b0;
   hexp_rsp_type          rsp_data;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr    = '0;
   logic [CSR_DATA_W-1:0] pwdata   = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hex_bytes_tracker tracker = new();
   int               words_sent = 0;
   int               burst_left = 0;
   int               idle_cycles = 0;
   int               rx_left = 0;
   logic [1:0]       rx_mode = 2'd0;

   hex_text_to_bytes_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // both handshakes sampled with pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) tracker.take_word(req_data);
         if (pop && !empty) tracker.match_result(rsp_data);
      end
   end

   // receiver stall pattern: free run, coin flip, one in four, mostly stalled
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = 2'($urandom_range(0, 3));
         rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      case (rx_mode)
         2'd0: pop <= 1'b1;
         2'd1: pop <= 1'($urandom_range(0, 1));
         2'd2: pop <= (rx_left % 4 == 0);
         default: pop <= ($urandom_range(0, 15) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [1:0] f, input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      push     <= 1'b1;
      req_data <= {f, c};
      do @(posedge clock); while (full);
      words_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(FUNC_CHAR, s[i]);
   endtask

   task automatic send_hex_digit(input bit force_zero);
      int         v;
      logic [7:0] c;
      v = force_zero ? 0 : $urandom_range(0, 15);
      if (v < 10) c = 8'("0" + v);
      else if ($urandom_range(0, 1)) c = 8'("A" + v - 10);
      else c = 8'("a" + v - 10);
      send_word(FUNC_CHAR, c);
   endtask

   task automatic send_separator();
      logic [7:0] seps[5];
      seps = '{":", ",", "-", "_", " "};
      send_word(FUNC_CHAR, seps[$urandom_range(0, 4)]);
   endtask

   // one input stream: a few arguments, mostly well formed, some noise
   task automatic send_random_stream();
      int n_args;
      int n_bytes;
      int r;
      n_args = $urandom_range(1, 4);
      for (int a = 0; a < n_args; a++) begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_word(FUNC_CHAR, "0");
         end else begin
            if (r < 45) begin
               send_word(FUNC_CHAR, "0");
               send_word(FUNC_CHAR, $urandom_range(0, 1) ? "x" : "X");
            end else if (r < 50) begin
               send_separator();
            end
            n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(0, 6);
            for (int b = 0; b < 2 * n_bytes; b++) begin
               send_hex_digit(b == 0 && $urandom_range(0, 4) == 0);
               if ($urandom_range(0, 5) == 0) send_separator();
               if ($urandom_range(0, 79) == 0)
                  send_word(FUNC_CHAR, 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 79) == 0)
                  send_word(FUNC_UNUSED, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 15) == 0) send_hex_digit(0);
         end
         // last argument is often left open at end of input
         if (a < n_args - 1 || $urandom_range(0, 1))
            send_word(FUNC_END_ARG, 8'($urandom_range(0, 255)));
      end
      send_word(FUNC_END_INPUT, 8'($urandom_range(0, 255)));
   endtask

   // wait for the clock first so the last accepted word is already in the tracker
   task automatic wait_drained();
      push <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAPACITY_ADDR;
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.capacity = value;
      @(posedge clock);
   endtask

   task automatic check_capacity(input logic [15:0] value);
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CAPACITY_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== CSR_DATA_W'(value)) begin
         $error("byte_capacity: expected %0d, got %0d", value, got);
         tracker.errors++;
      end
   endtask

   initial begin
      logic [15:0] caps[6];
      caps[0] = 16'd0;
      caps[1] = 16'hFFFF;
      caps[2] = 16'd1;
      caps[3] = 16'($urandom_range(2, 9));
      caps[4] = 16'd256;
      caps[5] = 16'($urandom_range(0, 65535));
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      check_capacity(CAPACITY_RESET);

      // prefixes of both cases, separators, open argument at end of input
      send_text("0x1A");
      send_word(FUNC_END_ARG, 8'h00);
      send_text("0Xf:F");
      send_word(FUNC_END_INPUT, 8'hFF);
      // lone zero is an odd nibble
      send_text("0");
      send_word(FUNC_END_ARG, 8'h00);
      send_word(FUNC_END_INPUT, 8'h00);
      // bad character, then words ignored after the error, unused func
      send_word(FUNC_CHAR, 8'h00);
      send_word(FUNC_CHAR, 8'hFF);
      send_word(FUNC_UNUSED, 8'hFF);
      send_word(FUNC_END_INPUT, 8'h00);
      // prefix only is an empty valid argument
      send_text("0x");
      send_word(FUNC_END_INPUT, 8'h00);
      // leading zero kept as a nibble, then a trailing odd nibble
      send_text("09 7");
      send_word(FUNC_END_INPUT, 8'h00);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         write_capacity(caps[p]);
         check_capacity(caps[p]);
         while (words_sent < 26 + (p + 1) * PHASE_WORDS) send_random_stream();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
